@@ rtl/core/sspd_pkg.sv @@
// Shared types and constants for the shutter sync pulse decoder.
`timescale 1ns / 1ps

package sspd_pkg;

    // Eye phase codes
    localparam logic [1:0] PH_OFF   = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    // Pulse timing marks in microseconds, relative to the pulse rising edge
    localparam logic [7:0] MARK_SYNC   = 8'd24;
    localparam logic [7:0] MARK_LOPEN  = 8'd44;
    localparam logic [7:0] MARK_RO     = 8'd69;
    localparam logic [7:0] MARK_RCLOSE = 8'd102;
    localparam logic [7:0] MARK_END    = 8'd142;

    // Configuration register indexes and reset values
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;
    localparam logic [7:0]  TOLERANCE_RESET = 8'd8;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd200;

    // One classified input item
    typedef struct packed {
        logic        tick;
        logic        level;
        logic [31:0] time_us;
    } sspd_item_t;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic       valid;
        sspd_item_t item;
    } sspd_head_t;

    // True when the elapsed time lies within mark +/- tol (wrap-aware)
    function automatic logic near_mark(
        input logic [31:0] elapsed,
        input logic [7:0]  mark,
        input logic [7:0]  tol
    );
        logic [31:0] diff_lo;
        logic [31:0] diff_hi;
        diff_lo = elapsed - {24'd0, mark} + {24'd0, tol};
        diff_hi = elapsed - {24'd0, mark} - {24'd0, tol};
        return !diff_lo[31] && (diff_hi[31] || (diff_hi == 32'd0));
    endfunction

endpackage

@@ rtl/core/sspd_front.sv @@
// Front end: accepts input items, classifies them and queues them for the decoder.
`timescale 1ns / 1ps

module sspd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic               level,
    input  logic [31:0]        time_us,
    output sspd_pkg::sspd_head_t head,
    input  logic               take
);

    sspd_pkg::sspd_item_t item_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_xfer;
    logic       out_xfer;

    assign full     = (count_reg == 2'd2);
    assign in_xfer  = push && !full;
    assign out_xfer = take && (count_reg != 2'd0);

    // Present the oldest queued item
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = item_mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ in_xfer;
        rd_ptr_next = rd_ptr_reg ^ out_xfer;
        count_next  = count_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Classify and store the incoming item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_mem[wr_ptr_reg].tick    <= mode;
            item_mem[wr_ptr_reg].level   <= level;
            item_mem[wr_ptr_reg].time_us <= time_us;
        end
    end

endmodule

@@ rtl/core/sspd_back.sv @@
// Back end: pulse timing state machine, configuration registers and result queue.
`timescale 1ns / 1ps

module sspd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sspd_pkg::sspd_head_t head,
    output logic                 take,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [15:0]          cfg_wdata,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           eye_phase
);

    localparam logic [2:0] ST_SCAN   = 3'd0;
    localparam logic [2:0] ST_RISE   = 3'd1;
    localparam logic [2:0] ST_SYNC   = 3'd2;
    localparam logic [2:0] ST_LCLOSE = 3'd3;
    localparam logic [2:0] ST_RCLOSE = 3'd4;
    localparam logic [2:0] ST_ROPEN  = 3'd5;

    logic [7:0]  tolerance_reg;
    logic [15:0] timeout_reg;
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [31:0] pulse_start_reg;
    logic [31:0] pulse_start_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;

    logic [31:0] elapsed;
    logic [31:0] over;
    logic        timed_out;
    logic        hit_sync;
    logic        hit_lopen;
    logic        hit_ro;
    logic        hit_rclose;
    logic        hit_end;
    logic        high;

    logic [1:0]  res_mem [2];
    logic        res_wr_reg;
    logic        res_rd_reg;
    logic [1:0]  res_count_reg;
    logic [1:0]  res_count_next;
    logic        res_out;

    // Take an item whenever the result queue has room
    assign take    = head.valid && (res_count_reg != 2'd2);
    assign res_out = pop && !empty;

    // Wrap-aware timing against the pulse start
    assign elapsed    = head.item.time_us - pulse_start_reg;
    assign over       = elapsed - {16'd0, timeout_reg};
    assign timed_out  = (over != 32'd0) && !over[31];
    assign high       = head.item.level;
    assign hit_sync   = sspd_pkg::near_mark(elapsed, sspd_pkg::MARK_SYNC, tolerance_reg);
    assign hit_lopen  = sspd_pkg::near_mark(elapsed, sspd_pkg::MARK_LOPEN, tolerance_reg);
    assign hit_ro     = sspd_pkg::near_mark(elapsed, sspd_pkg::MARK_RO, tolerance_reg);
    assign hit_rclose = sspd_pkg::near_mark(elapsed, sspd_pkg::MARK_RCLOSE, tolerance_reg);
    assign hit_end    = sspd_pkg::near_mark(elapsed, sspd_pkg::MARK_END, tolerance_reg);

    // Decode one item
    always_comb
    begin
        state_next       = state_reg;
        pulse_start_next = pulse_start_reg;
        phase_next       = phase_reg;
        if (take)
        begin
            if (head.item.tick)
            begin
                if (timed_out)
                begin
                    state_next       = ST_SCAN;
                    phase_next       = sspd_pkg::PH_OFF;
                    pulse_start_next = head.item.time_us;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_RISE:
                    begin
                        state_next = ST_SCAN;
                        if (!high && hit_sync)
                            state_next = ST_SYNC;
                        else if (!high && hit_lopen)
                            phase_next = sspd_pkg::PH_LEFT;
                    end
                    ST_SYNC:
                    begin
                        priority if (high && hit_lopen)
                            state_next = ST_LCLOSE;
                        else if (high && hit_ro)
                            state_next = ST_ROPEN;
                        else if (high && hit_rclose)
                            state_next = ST_RCLOSE;
                        else
                            state_next = ST_SCAN;
                    end
                    ST_LCLOSE:
                    begin
                        if (!high && hit_ro)
                            phase_next = sspd_pkg::PH_OFF;
                        state_next = ST_SCAN;
                    end
                    ST_ROPEN:
                    begin
                        if (!high && hit_rclose)
                            phase_next = sspd_pkg::PH_RIGHT;
                        state_next = ST_SCAN;
                    end
                    ST_RCLOSE:
                    begin
                        if (!high && hit_end)
                            phase_next = sspd_pkg::PH_OFF;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_SCAN;
                        if (high)
                        begin
                            state_next       = ST_RISE;
                            pulse_start_next = head.item.time_us;
                        end
                    end
                endcase
            end
        end
    end

    // Hold configuration, decoder state and result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg   <= sspd_pkg::TOLERANCE_RESET;
            timeout_reg     <= sspd_pkg::TIMEOUT_RESET;
            state_reg       <= ST_SCAN;
            pulse_start_reg <= 32'd0;
            phase_reg       <= sspd_pkg::PH_OFF;
            res_wr_reg      <= 1'b0;
            res_rd_reg      <= 1'b0;
            res_count_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_we && (cfg_addr == sspd_pkg::CFG_TOLERANCE))
                tolerance_reg <= cfg_wdata[7:0];
            if (cfg_we && (cfg_addr == sspd_pkg::CFG_TIMEOUT))
                timeout_reg <= cfg_wdata;
            state_reg       <= state_next;
            pulse_start_reg <= pulse_start_next;
            phase_reg       <= phase_next;
            res_wr_reg      <= res_wr_reg ^ take;
            res_rd_reg      <= res_rd_reg ^ res_out;
            res_count_reg   <= res_count_next;
        end
    end

    assign res_count_next = res_count_reg + {1'b0, take} - {1'b0, res_out};

    // Queue the phase produced by each item
    always_ff @(posedge clk)
    begin
        if (take)
            res_mem[res_wr_reg] <= phase_next;
    end

    assign empty     = (res_count_reg == 2'd0);
    assign eye_phase = res_mem[res_rd_reg];

endmodule

@@ rtl/core/shutter_sync_pulse_decoder_core.sv @@
// Top level of the shutter sync pulse decoder.
// An item is registered in the front queue, then the back end decodes it and writes its
// phase into the result queue, from which it can transfer out.
// Throughput: one item per cycle while the result queue has room (combinational decode).
// Each side has a two-entry queue, so the input keeps moving while a result waits.
// Reset (rst_n low, asynchronous) empties both queues, restores tolerance 8 us and
// timeout 200 us, returns the decoder to scanning with pulse start zero and phase off.
`timescale 1ns / 1ps

module shutter_sync_pulse_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic        level,
    input  logic [31:0] time_us,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  eye_phase,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    sspd_pkg::sspd_head_t head;
    logic                 take;

    sspd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .mode    (mode),
        .level   (level),
        .time_us (time_us),
        .head    (head),
        .take    (take)
    );

    sspd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .take      (take),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .empty     (empty),
        .pop       (pop),
        .eye_phase (eye_phase)
    );

endmodule

@@ rtl/core/sspd_checker.sv @@
// Port-level checker for the shutter sync pulse decoder, bound to the top level.
`timescale 1ns / 1ps

module sspd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [1:0] eye_phase
);

    logic [2:0] in_flight_reg;
    logic [2:0] in_flight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;
    assign in_flight_next = in_flight_reg + {2'd0, in_xfer} - {2'd0, out_xfer};

    // Track items transferred in whose results are not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_flight_reg <= 3'd0;
        else
            in_flight_reg <= in_flight_next;
    end

    // A result never appears without an item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (in_flight_reg != 3'd0))
        else $error("result shown with no item outstanding");

    // Full only once both queues hold items
    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (in_flight_reg >= 3'd2))
        else $error("full raised with fewer than two items outstanding");

    // Shown phase is always a legal code
    a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (eye_phase != 2'd3))
        else $error("illegal eye phase code");

    // A waiting result holds until it is taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(eye_phase)))
        else $error("waiting result changed before transfer");

endmodule

bind shutter_sync_pulse_decoder_core sspd_checker u_sspd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .eye_phase (eye_phase)
);
